### design/echo_range_mean_median_filter_top_assert.svh
// ============================================================================
// Echo range filter assertion macros
// Shared concurrent assertion forms. Each use relies on clk and rst_n being
// in scope of the module that expands it.
// ============================================================================
`ifndef ECHO_RANGE_MEAN_MEDIAN_FILTER_TOP_ASSERT_SVH
`define ECHO_RANGE_MEAN_MEDIAN_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge out of reset.
`define ERMMF_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define ERMMF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one in the following cycle.
`define ERMMF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ERMMF_ASSERT(name, cond, msg)
`define ERMMF_ASSERT_IMPL(name, ante, cons, msg)
`define ERMMF_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### design/ermmf_pkg.sv
// ============================================================================
// Echo range filter package
// Widths, register codes, reset values and shared types of the echo range
// mean and median filter.
// ============================================================================
`default_nettype none

package ermmf_pkg;

    // Field widths.
    localparam int TICKS_W = 16;
    localparam int US_W    = 20;
    localparam int DIST_W  = 24;
    localparam int CFG_W   = 16;
    localparam int UPT_W   = 5;
    localparam int IDX_W   = 2;

    // Distance history.
    localparam int RING_DEPTH = 5;
    localparam int SLOT_W     = 3;
    localparam int RANK_W     = 3;
    localparam int SUM_W      = 27;

    // Division of the history sum by five: multiply by ceil(2^29 / 5) and
    // shift. Exact for every sum of five 24-bit values.
    localparam int             MEAN_SHIFT = 29;
    localparam logic [SUM_W-1:0] MEAN_RECIP = 27'd107374183;

    // Rounding shift for the Q16 to Q8 step.
    localparam int ROUND_SHIFT = 8;

    // Input function codes.
    localparam logic FUNC_ARM     = 1'b0;
    localparam logic FUNC_CAPTURE = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_SLOPE       = 2'd0;
    localparam logic [IDX_W-1:0] CFG_INTERCEPT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_US_PER_TICK = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] SLOPE_RESET     = 16'd1131;
    localparam logic [CFG_W-1:0] INTERCEPT_RESET = 16'd199;
    localparam logic [UPT_W-1:0] UPT_RESET       = 5'd4;

    typedef logic [TICKS_W-1:0] ticks_t;
    typedef logic [US_W-1:0]    us_t;
    typedef logic [DIST_W-1:0]  dist_t;

    // Saturation limits.
    localparam us_t   US_MAX   = '1;
    localparam dist_t DIST_MAX = '1;

    // A measurement handed from the front to the queue.
    typedef struct packed {
        logic   push;
        ticks_t ticks;
    } job_t;

    // Configuration seen by the arithmetic.
    typedef struct packed {
        logic [CFG_W-1:0] slope;
        logic [CFG_W-1:0] intercept;
        logic [UPT_W-1:0] us_per_tick;
    } cfg_t;

endpackage

`default_nettype wire

### design/ermmf_front.sv
// ============================================================================
// Echo range filter front end
// Tracks the arm / rising edge / falling edge sequence and emits the pulse
// width in ticks when a falling edge capture completes a measurement.
// ============================================================================
`default_nettype none

module ermmf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic             func,
    input  wire ermmf_pkg::ticks_t capture_time,
    output ermmf_pkg::job_t       job
);
    import ermmf_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_RISE = 2'd1;
    localparam logic [1:0] PH_WAIT_FALL = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    ticks_t     start_time_reg;
    ticks_t     start_time_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    // Sequence decode; the width is a plain modulo 2^16 difference.
    always_comb
    begin
        phase_next      = phase_reg;
        start_time_next = start_time_reg;
        job.push        = 1'b0;
        job.ticks       = capture_time - start_time_reg;
        if (accept)
        begin
            if (func == FUNC_ARM)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_WAIT_RISE;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT_RISE:
                    begin
                        start_time_next = capture_time;
                        phase_next      = PH_WAIT_FALL;
                    end
                    PH_WAIT_FALL:
                    begin
                        job.push   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            start_time_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            start_time_reg <= start_time_next;
        end
    end

endmodule

`default_nettype wire

### design/ermmf_queue.sv
// ============================================================================
// Echo range filter job queue
// Small FIFO of pulse widths between the front end and the arithmetic
// pipeline, so either side can stall on its own.
// ============================================================================
`default_nettype none

`include "echo_range_mean_median_filter_top_assert.svh"

module ermmf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ermmf_pkg::job_t   job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output ermmf_pkg::ticks_t      ticks
);
    import ermmf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ticks_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign ticks = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (job.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({job.push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (job.push)
        begin
            entry_reg[wr_ptr_reg] <= job.ticks;
        end
    end

    `ERMMF_ASSERT(a_q_count_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `ERMMF_ASSERT_IMPL(a_q_pop_nonempty, pop, valid, "queue popped while empty")
    `ERMMF_ASSERT_IMPL(a_q_push_room, job.push, !full, "queue pushed while full")
    `ERMMF_ASSERT_NEXT(a_q_push_grows, job.push && !pop,
                       count_reg == $past(count_reg) + CNT_W'(1), "queue count did not grow")

endmodule

`default_nettype wire

### design/ermmf_back.sv
// ============================================================================
// Echo range filter arithmetic pipeline
// Five stages: ticks to microseconds, linear distance map, history write,
// sum and median of the history, mean by reciprocal multiply.
// ============================================================================
`default_nettype none

`include "echo_range_mean_median_filter_top_assert.svh"

module ermmf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ermmf_pkg::cfg_t   cfg,
    input  wire logic              q_valid,
    input  wire ermmf_pkg::ticks_t q_ticks,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ermmf_pkg::ticks_t      pulse_ticks,
    output ermmf_pkg::us_t         pulse_us,
    output ermmf_pkg::dist_t       distance_q8,
    output ermmf_pkg::dist_t       mean_q8,
    output ermmf_pkg::dist_t       median_q8
);
    import ermmf_pkg::*;

    localparam int USP_W  = TICKS_W + UPT_W;
    localparam int DPR_W  = CFG_W + US_W;
    localparam int DSUM_W = DPR_W - ROUND_SHIFT + 2;
    localparam int MPR_W  = 2 * SUM_W;

    logic adv;

    // Stage registers.
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    ticks_t s1_ticks_reg, s2_ticks_reg, s3_ticks_reg, s4_ticks_reg, s5_ticks_reg;
    us_t    s1_us_reg, s2_us_reg, s3_us_reg, s4_us_reg, s5_us_reg;
    dist_t  s2_dist_reg, s3_dist_reg, s4_dist_reg, s5_dist_reg;
    logic [SUM_W-1:0] s4_sum_reg;
    dist_t  s4_median_reg, s5_median_reg, s5_mean_reg;

    // History.
    dist_t             ring_reg [RING_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // Combinational results of each stage.
    logic [USP_W-1:0]   us_prod;
    us_t                us_sat;
    logic [DPR_W-1:0]   dist_prod;
    logic [DPR_W:0]     dist_round;
    logic [DSUM_W-1:0]  dist_sum;
    dist_t              dist_sat;
    logic [SUM_W-1:0]   ring_sum;
    dist_t              ring_median;
    logic [MPR_W-1:0]   mean_prod;

    // The whole pipeline moves together whenever the output can take a word.
    assign adv       = !s5_valid_reg || out_ready;
    assign pop       = adv && q_valid;
    assign out_valid = s5_valid_reg;

    // Stage one: ticks times microseconds per tick, saturated at 20 bits.
    assign us_prod = USP_W'(q_ticks) * USP_W'(cfg.us_per_tick);
    assign us_sat  = (us_prod[USP_W-1:US_W] != '0) ? US_MAX : us_prod[US_W-1:0];

    // Stage two: Q16 product rounded half up to Q8, plus offset, saturated.
    assign dist_prod  = DPR_W'(cfg.slope) * DPR_W'(s1_us_reg);
    assign dist_round = {1'b0, dist_prod} + (DPR_W + 1)'(128);
    assign dist_sum   = DSUM_W'(dist_round[DPR_W:ROUND_SHIFT]) + DSUM_W'(cfg.intercept);
    assign dist_sat   = (dist_sum[DSUM_W-1:DIST_W] != '0) ? DIST_MAX : dist_sum[DIST_W-1:0];

    // Stage three: next history slot.
    assign slot_next = (slot_reg >= SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);

    // Stage four: sum of the history and its median by rank. Ties rank by
    // position, so exactly one entry has rank two.
    always_comb
    begin
        logic [RANK_W-1:0] rank;
        ring_sum    = '0;
        ring_median = '0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_sum = ring_sum + SUM_W'(ring_reg[i]);
            rank = '0;
            for (int j = 0; j < RING_DEPTH; j++)
            begin
                if ((ring_reg[j] < ring_reg[i]) || ((ring_reg[j] == ring_reg[i]) && (j < i)))
                begin
                    rank = rank + RANK_W'(1);
                end
            end
            if (rank == RANK_W'(RING_DEPTH / 2))
            begin
                ring_median = ring_median | ring_reg[i];
            end
        end
    end

    // Stage five: mean as sum times reciprocal of five.
    assign mean_prod = MPR_W'(s4_sum_reg) * MPR_W'(MEAN_RECIP);

    // Valid bits and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            slot_reg     <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            if (s2_valid_reg)
            begin
                slot_reg <= slot_next;
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    if (slot_reg == SLOT_W'(i))
                    begin
                        ring_reg[i] <= s2_dist_reg;
                    end
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ticks_reg  <= q_ticks;
            s1_us_reg     <= us_sat;
            s2_ticks_reg  <= s1_ticks_reg;
            s2_us_reg     <= s1_us_reg;
            s2_dist_reg   <= dist_sat;
            s3_ticks_reg  <= s2_ticks_reg;
            s3_us_reg     <= s2_us_reg;
            s3_dist_reg   <= s2_dist_reg;
            s4_ticks_reg  <= s3_ticks_reg;
            s4_us_reg     <= s3_us_reg;
            s4_dist_reg   <= s3_dist_reg;
            s4_sum_reg    <= ring_sum;
            s4_median_reg <= ring_median;
            s5_ticks_reg  <= s4_ticks_reg;
            s5_us_reg     <= s4_us_reg;
            s5_dist_reg   <= s4_dist_reg;
            s5_median_reg <= s4_median_reg;
            s5_mean_reg   <= mean_prod[MEAN_SHIFT + DIST_W - 1:MEAN_SHIFT];
        end
    end

    assign pulse_ticks = s5_ticks_reg;
    assign pulse_us    = s5_us_reg;
    assign distance_q8 = s5_dist_reg;
    assign mean_q8     = s5_mean_reg;
    assign median_q8   = s5_median_reg;

    `ERMMF_ASSERT(a_b_slot_range, slot_reg < SLOT_W'(RING_DEPTH), "history slot out of range")
    `ERMMF_ASSERT_NEXT(a_b_slot_step, adv && s2_valid_reg, slot_reg != $past(slot_reg),
                       "history slot did not move after a write")
    `ERMMF_ASSERT_IMPL(a_b_stall_hold, s5_valid_reg && !out_ready, !pop,
                       "queue popped while the output is stalled")

endmodule

`default_nettype wire

### design/echo_range_mean_median_filter_top.sv
// ============================================================================
// Echo range mean and median filter
// Measures echo pulse widths from timer captures and reports the distance
// with the mean and median of the last five distances.
// ============================================================================
// Usage:
//   Input words (in_valid/in_ready) carry func and capture_time. An arm word
//   while idle starts a measurement, the next capture word latches the start
//   time and the one after it closes the pulse and yields one output word.
//   All other words are absorbed without output.
//   Output words (out_valid/out_ready) carry pulse_ticks, pulse_us,
//   distance_q8, mean_q8 and median_q8.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; indexes beyond the register list are dropped. Write only
//   while no measurement is in flight.
//   A closed pulse passes through the job queue and then the five-stage
//   arithmetic pipeline to its output word. Throughput: one input word per
//   cycle while in_ready is high; the pipeline takes one job a cycle unless
//   the output stalls. When the receiver stalls, the output register holds,
//   the pipeline freezes, the job queue fills and then in_ready drops.
//   Reset clears the sequence state, the queue, the pipeline, the distance
//   history and the slot pointer, and restores the register reset values.
// ============================================================================
`default_nettype none

module echo_range_mean_median_filter_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            func,
    input  wire logic [ermmf_pkg::TICKS_W-1:0]   capture_time,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ermmf_pkg::TICKS_W-1:0]        pulse_ticks,
    output logic [ermmf_pkg::US_W-1:0]           pulse_us,
    output logic [ermmf_pkg::DIST_W-1:0]         distance_q8,
    output logic [ermmf_pkg::DIST_W-1:0]         mean_q8,
    output logic [ermmf_pkg::DIST_W-1:0]         median_q8,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ermmf_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [ermmf_pkg::CFG_W-1:0]     cfg_data
);
    import ermmf_pkg::*;

    cfg_t   cfg_reg;
    job_t   job;
    logic   q_full;
    logic   q_valid;
    ticks_t q_ticks;
    logic   pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope       <= SLOPE_RESET;
            cfg_reg.intercept   <= INTERCEPT_RESET;
            cfg_reg.us_per_tick <= UPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLOPE:       cfg_reg.slope       <= cfg_data;
                CFG_INTERCEPT:   cfg_reg.intercept   <= cfg_data;
                CFG_US_PER_TICK: cfg_reg.us_per_tick <= cfg_data[UPT_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Sequence tracking.
    ermmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .capture_time (capture_time),
        .job          (job)
    );

    // Job queue.
    ermmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .ticks (q_ticks)
    );

    // Arithmetic pipeline.
    ermmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_ticks     (q_ticks),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_ticks (pulse_ticks),
        .pulse_us    (pulse_us),
        .distance_q8 (distance_q8),
        .mean_q8     (mean_q8),
        .median_q8   (median_q8)
    );

endmodule

`default_nettype wire
